[sv/fak_pkg.sv]
package fak_pkg;

  localparam int unsigned WindowSamples = 10;
  localparam int unsigned DefChannels   = 16;
  localparam int unsigned CfgIdxW       = 2;
  localparam int unsigned CfgDataW      = 16;

  localparam logic [CfgIdxW-1:0] CfgProcNoise = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMeasNoise = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgInitVar   = 2'd2;

  localparam logic [15:0] RstProcNoise = 16'd66;
  localparam logic [15:0] RstMeasNoise = 16'd13107;
  localparam logic [15:0] RstInitVar   = 16'd1311;

  typedef struct packed {
    logic [11:0] sample;
    logic [3:0]  channel;
  } in_item_t;

  typedef struct packed {
    logic [20:0] raw_amplitude;
    logic [15:0] filtered_amplitude;
    logic [3:0]  result_channel;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_ACC,
    ST_SQ,
    ST_SQRT,
    ST_LOAD,
    ST_DIV,
    ST_UPD1,
    ST_UPD2,
    ST_OUT
  } fak_state_e;

  typedef struct packed {
    logic init_step;
    logic load_item;
    logic acc_step;
    logic sq_step;
    logic sqrt_start;
    logic sqrt_step;
    logic kal_load;
    logic div_start;
    logic div_step;
    logic upd1;
    logic upd2;
    logic emit;
  } fak_cmd_t;

  typedef struct packed {
    logic init_done;
    logic last_pos;
    logic sq_done;
    logic sqrt_done;
    logic div_done;
    logic ch_valid;
  } fak_sts_t;

  function automatic logic signed [15:0] cos_coef(input logic [3:0] p);
    case (p)
      4'd0: cos_coef = 16'sd5302;
      4'd1: cos_coef = 16'sd2025;
      4'd2: cos_coef = -16'sd2025;
      4'd3: cos_coef = -16'sd5302;
      4'd4: cos_coef = -16'sd6554;
      4'd5: cos_coef = -16'sd5302;
      4'd6: cos_coef = -16'sd2025;
      4'd7: cos_coef = 16'sd2025;
      4'd8: cos_coef = 16'sd5302;
      4'd9: cos_coef = 16'sd6554;
      default: cos_coef = 16'sd0;
    endcase
  endfunction

  function automatic logic signed [15:0] sin_coef(input logic [3:0] p);
    case (p)
      4'd0: sin_coef = 16'sd3850;
      4'd1: sin_coef = 16'sd6232;
      4'd2: sin_coef = 16'sd6232;
      4'd3: sin_coef = 16'sd3850;
      4'd5: sin_coef = -16'sd3850;
      4'd6: sin_coef = -16'sd6232;
      4'd7: sin_coef = -16'sd6232;
      4'd8: sin_coef = -16'sd3850;
      default: sin_coef = 16'sd0;
    endcase
  endfunction

endpackage

[sv/fak_ctrl.sv]
module fak_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  fak_pkg::fak_sts_t sts_i,
  output fak_pkg::fak_cmd_t cmd_o
);
  import fak_pkg::*;

  fak_state_e state_q, state_d;
  logic       ov_q, ov_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: if (sts_i.init_done) state_d = ST_IDLE;
      ST_IDLE: if (in_valid_i) state_d = ST_ACC;
      ST_ACC:  state_d = sts_i.last_pos ? ST_SQ : ST_IDLE;
      ST_SQ:   if (sts_i.sq_done) state_d = ST_SQRT;
      ST_SQRT: if (sts_i.sqrt_done) state_d = sts_i.ch_valid ? ST_LOAD : ST_OUT;
      ST_LOAD: state_d = ST_DIV;
      ST_DIV:  if (sts_i.div_done) state_d = ST_UPD1;
      ST_UPD1: state_d = ST_UPD2;
      ST_UPD2: state_d = ST_OUT;
      ST_OUT:  if (!ov_q || !out_stall_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = (state_q != ST_IDLE);
    ov_d       = ov_q && out_stall_i;
    case (state_q)
      ST_INIT: cmd_o.init_step = 1'b1;
      ST_IDLE: cmd_o.load_item = in_valid_i;
      ST_ACC:  begin
        cmd_o.acc_step   = 1'b1;
        cmd_o.sqrt_start = sts_i.last_pos;
      end
      ST_SQ:   cmd_o.sq_step = 1'b1;
      ST_SQRT: cmd_o.sqrt_step = 1'b1;
      ST_LOAD: begin
        cmd_o.kal_load  = 1'b1;
        cmd_o.div_start = 1'b1;
      end
      ST_DIV:  cmd_o.div_step = 1'b1;
      ST_UPD1: cmd_o.upd1 = 1'b1;
      ST_UPD2: cmd_o.upd2 = 1'b1;
      ST_OUT:  if (!ov_q || !out_stall_i) begin
        cmd_o.emit = 1'b1;
        ov_d       = 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid_o = ov_q;

endmodule

[sv/fak_dp.sv]
module fak_dp #(
  parameter int unsigned CHANNELS = fak_pkg::DefChannels
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  fak_pkg::in_item_t           in_data_i,
  input  logic                        cfg_we_i,
  input  logic [fak_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [fak_pkg::CfgDataW-1:0] cfg_data_i,
  input  fak_pkg::fak_cmd_t           cmd_i,
  output fak_pkg::fak_sts_t           sts_o,
  output fak_pkg::out_item_t          out_data_o
);
  import fak_pkg::*;

  localparam int unsigned ChW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // config
  logic [15:0] q_noise_q, r_noise_q, init_var_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_noise_q  <= RstProcNoise;
      r_noise_q  <= RstMeasNoise;
      init_var_q <= RstInitVar;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgProcNoise: q_noise_q  <= cfg_data_i;
        CfgMeasNoise: r_noise_q  <= cfg_data_i;
        CfgInitVar:   init_var_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // filter state memories, loaded by a sweep after reset (estimates zero, variances from the init register)
  logic [31:0] est_mem [CHANNELS];
  logic [15:0] var_mem [CHANNELS];
  logic [31:0] est_rd_q;
  logic [15:0] var_rd_q;
  logic [ChW:0] clr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (cmd_i.init_step && (clr_q != CHANNELS[ChW:0])) clr_q <= clr_q + 1'b1;
  end
  assign sts_o.init_done = (clr_q == CHANNELS[ChW:0]);

  // accumulation
  in_item_t          item_q;
  logic [3:0]        pos_q;
  logic signed [15:0] acc_c_q, acc_s_q;

  function automatic logic signed [15:0] acc_upd(input logic signed [15:0] a,
                                                 input logic [11:0] s,
                                                 input logic signed [15:0] c);
    logic signed [31:0] t;
    logic signed [31:0] r;
    t = {{16{a[15]}}, a} * 32'sd32768 + $signed({20'd0, s}) * {{16{c[15]}}, c};
    r = (t < 0) ? -((-t) >>> 15) : (t >>> 15);
    acc_upd = r[15:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      acc_c_q <= '0;
      acc_s_q <= '0;
    end else if (cmd_i.acc_step) begin
      acc_c_q <= acc_upd(acc_c_q, item_q.sample, cos_coef(pos_q));
      acc_s_q <= acc_upd(acc_s_q, item_q.sample, sin_coef(pos_q));
      pos_q   <= sts_o.last_pos ? 4'd0 : pos_q + 4'd1;
    end else if (cmd_i.emit) begin
      acc_c_q <= '0;
      acc_s_q <= '0;
    end
  end
  always_ff @(posedge clk_i) if (cmd_i.load_item) item_q <= in_data_i;
  assign sts_o.last_pos = (pos_q >= 4'(WindowSamples - 1));

  // sum of squares: one square per cycle, accumulators hold until emit
  logic [30:0] sumsq_q;
  logic        sqph_q;
  logic [15:0] ac_abs, as_abs, sqop;
  assign ac_abs = acc_c_q[15] ? 16'(-acc_c_q) : acc_c_q;
  assign as_abs = acc_s_q[15] ? 16'(-acc_s_q) : acc_s_q;
  assign sqop   = sqph_q ? as_abs : ac_abs;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sqph_q <= 1'b0;
    else if (cmd_i.sq_step) sqph_q <= !sqph_q;
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_start) begin
      sumsq_q <= '0;
    end else if (cmd_i.sq_step) begin
      sumsq_q <= sumsq_q + {15'd0, sqop} * {15'd0, sqop};
    end
  end
  assign sts_o.sq_done = sqph_q;

  // restoring square root of sumsq<<16, two radicand bits per cycle
  logic [47:0] rad_q;
  logic [23:0] root_q;
  logic [25:0] rem_q;
  logic [4:0]  sqc_q;
  logic [25:0] trial;
  logic [25:0] rem_sh;
  assign rem_sh = {rem_q[23:0], rad_q[47:46]};
  assign trial  = {root_q, 2'b01};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sqc_q <= '0;
    else if (cmd_i.sq_step && sqph_q) sqc_q <= 5'd24;
    else if (cmd_i.sqrt_step && sqc_q != 0) sqc_q <= sqc_q - 5'd1;
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_step && sqph_q) begin
      rad_q  <= {1'b0, sumsq_q + {15'd0, as_abs} * {15'd0, as_abs}, 16'd0};
      root_q <= '0;
      rem_q  <= '0;
    end else if (cmd_i.sqrt_step && sqc_q != 0) begin
      rad_q <= {rad_q[45:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[22:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[22:0], 1'b0};
      end
    end
  end
  assign sts_o.sqrt_done = (sqc_q == 0) && cmd_i.sqrt_step;
  logic [20:0] raw;
  assign raw = (root_q > 24'd2097151) ? 21'h1FFFFF : root_q[20:0];

  logic ch_ok;
  assign ch_ok = ({3'b0, item_q.channel} < 7'(CHANNELS));
  assign sts_o.ch_valid = ch_ok;
  logic [ChW-1:0] ch_idx;
  assign ch_idx = ChW'(item_q.channel);

  // channel state read while the root runs
  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_step) begin
      est_rd_q <= est_mem[ch_idx];
      var_rd_q <= var_mem[ch_idx];
    end
  end

  // Kalman: gain by restoring division, 17 quotient bits
  logic [16:0] p_q;
  logic [17:0] den_q;
  logic [31:0] est_q;
  logic [16:0] kg_q;
  logic [17:0] drem_q;
  logic [32:0] dnum_q;
  logic [5:0]  dc_q;
  logic [18:0] drs;
  assign drs = {drem_q, dnum_q[32]};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dc_q <= '0;
    else if (cmd_i.div_start) dc_q <= 6'd33;
    else if (cmd_i.div_step && dc_q != 0) dc_q <= dc_q - 6'd1;
  end
  assign sts_o.div_done = (dc_q == 0) && cmd_i.div_step;

  logic [16:0] p_n;
  assign p_n = {1'b0, var_rd_q} + {1'b0, q_noise_q};
  always_ff @(posedge clk_i) begin
    if (cmd_i.kal_load) begin
      p_q    <= p_n;
      den_q  <= {1'b0, p_n} + {2'b0, r_noise_q};
      est_q  <= est_rd_q;
      dnum_q <= {p_n, 16'd0};
      drem_q <= '0;
      kg_q   <= '0;
    end else if (cmd_i.div_step && dc_q != 0) begin
      dnum_q <= {dnum_q[31:0], 1'b0};
      if (drs >= {1'b0, den_q}) begin
        drem_q <= 18'(drs - {1'b0, den_q});
        kg_q   <= {kg_q[15:0], 1'b1};
      end else begin
        drem_q <= drs[17:0];
        kg_q   <= {kg_q[15:0], 1'b0};
      end
    end
  end

  // update: product per stage, registered
  logic [31:0] meas;
  logic [31:0] diff_q;
  logic        up_q;
  logic [48:0] kd_q;
  logic [33:0] nvp_q;
  logic [16:0] kgz;
  assign meas = {3'b0, raw, 8'd0};
  assign kgz  = (den_q == 0) ? 17'd0 : kg_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.upd1) begin
      kd_q  <= 49'(kgz) * 49'(meas >= est_q ? meas - est_q : est_q - meas);
      up_q  <= (meas >= est_q);
      nvp_q <= 34'(17'h10000 - kgz) * 34'(p_q);
    end
  end
  logic [32:0] est_n;
  logic [17:0] nv;
  assign est_n = up_q ? {1'b0, est_q} + {1'b0, kd_q[47:16]}
                      : {1'b0, est_q} - {1'b0, kd_q[47:16]};
  assign nv = nvp_q[33:16];
  logic [31:0] est_sat;
  assign est_sat = est_n[32] ? 32'hFFFF_FFFF : est_n[31:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_step && !sts_o.init_done) begin
      est_mem[clr_q[ChW-1:0]] <= '0;
      var_mem[clr_q[ChW-1:0]] <= init_var_q;
    end else if (cmd_i.upd2) begin
      est_mem[ch_idx] <= est_sat;
      var_mem[ch_idx] <= (nv > 18'd65535) ? 16'hFFFF : nv[15:0];
      diff_q          <= est_sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_data_o.raw_amplitude      <= raw;
      out_data_o.filtered_amplitude <= ch_ok ? diff_q[31:16] : 16'd0;
      out_data_o.result_channel     <= item_q.channel;
    end
  end

endmodule

[sv/fundamental_amplitude_kalman_core.sv]
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid_i/in_stall_o | fak_pkg::in_item_t (sample, channel)
// out     | output    | out_valid_o/out_stall_i | fak_pkg::out_item_t
// cfg     | input     | cfg_we_i              | cfg_idx_i, cfg_data_i
// A sample that does not close a window is accepted, then accumulated.
// A closing sample goes on to 2 squares, the square root and the gain division
// on iterative units; the filter is skipped for a channel outside CHANNELS.
// After reset a sweep over all CHANNELS entries loads the filter state; no transfer in.
// A stalled result holds; later samples are still taken, but the next closing
// sample waits in the output state until the result is taken.
module fundamental_amplitude_kalman_core #(
  parameter int unsigned CHANNELS = fak_pkg::DefChannels
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  fak_pkg::in_item_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output fak_pkg::out_item_t          out_data_o,
  input  logic                        cfg_we_i,
  input  logic [fak_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [fak_pkg::CfgDataW-1:0] cfg_data_i
);
  import fak_pkg::*;

  fak_cmd_t cmd;
  fak_sts_t sts;

  // sequencer
  fak_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  // accumulators, root, divider, channel state
  fak_dp #(.CHANNELS(CHANNELS)) u_dp (
    .clk_i, .rst_ni, .in_data_i, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .cmd_i(cmd), .sts_o(sts), .out_data_o
  );

endmodule

[dv/tb_fundamental_amplitude_kalman_core.sv]
`timescale 1ns / 1ps

module tb_fundamental_amplitude_kalman_core;
  import fak_pkg::*;

  localparam int unsigned NumCh = DefChannels;
  // Worst slot per sample: idle gap, block processing and receiver stall, plus long hold-offs.
  localparam longint CycleLimit = 400000;
  localparam logic [CfgIdxW-1:0] CfgNoReg = 2'd3;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_item_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_item_t out_data_o;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  fundamental_amplitude_kalman_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  // Shadow of the block's state.
  logic [15:0] q_noise, r_noise;
  logic signed [15:0] acc_cos, acc_sin;
  int unsigned win_pos;
  logic [31:0] est_mem [NumCh];
  logic [15:0] var_mem [NumCh];

  out_item_t amp_queue[$];
  int errors;
  int n_sent;
  int n_windows;
  longint cycles = 0;
  bit hold_off;  // receiver stalls continuously while set

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[fundamental_amplitude_kalman_core] ERROR");
      $finish;
    end
  end

  function automatic logic signed [15:0] cos_tab(int unsigned p);
    int t[10] = '{5302, 2025, -2025, -5302, -6554, -5302, -2025, 2025, 5302, 6554};
    return 16'(t[p]);
  endfunction

  function automatic logic signed [15:0] sin_tab(int unsigned p);
    int t[10] = '{3850, 6232, 6232, 3850, 0, -3850, -6232, -6232, -3850, 0};
    return 16'(t[p]);
  endfunction

  // One accumulator step, truncation toward zero.
  function automatic logic signed [15:0] acc_next(logic signed [15:0] acc,
                                                  logic [11:0] s, logic signed [15:0] c);
    longint t;
    longint r;
    t = longint'(acc) * 32768 + longint'(s) * longint'(c);
    r = t / 32768;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Predicts the amplitude result for one sample, if it closes a window.
  task automatic predict_amplitude(in_item_t it);
    longint unsigned a, b, raw, nowp, den, kg, meas, est, nv, filt;
    out_item_t r;
    acc_cos = acc_next(acc_cos, it.sample, cos_tab(win_pos));
    acc_sin = acc_next(acc_sin, it.sample, sin_tab(win_pos));
    if (win_pos + 1 < WindowSamples) begin
      win_pos++;
      return;
    end
    a = acc_cos < 0 ? -longint'(acc_cos) : longint'(acc_cos);
    b = acc_sin < 0 ? -longint'(acc_sin) : longint'(acc_sin);
    raw = int_sqrt((a * a + b * b) << 16);
    if (raw > 2097151) raw = 2097151;
    filt = 0;
    if (it.channel < NumCh) begin
      nowp = var_mem[it.channel] + q_noise;
      den = nowp + r_noise;
      kg = den != 0 ? (nowp << 16) / den : 0;
      meas = raw << 8;
      est = est_mem[it.channel];
      if (meas >= est) est += (kg * (meas - est)) >> 16;
      else est -= (kg * (est - meas)) >> 16;
      if (est > 64'hFFFF_FFFF) est = 64'hFFFF_FFFF;
      est_mem[it.channel] = 32'(est);
      nv = ((65536 - kg) * nowp) >> 16;
      if (nv > 65535) nv = 65535;
      var_mem[it.channel] = 16'(nv);
      filt = est >> 16;
      if (filt > 65535) filt = 65535;
    end
    acc_cos = 0;
    acc_sin = 0;
    win_pos = 0;
    r.raw_amplitude = 21'(raw);
    r.filtered_amplitude = 16'(filt);
    r.result_channel = it.channel;
    amp_queue.push_back(r);
  endtask

  // Sends one sample; the gap before it is drawn at random unless suppressed.
  // Valid stays high after the transfer so the next sample can follow directly;
  // the caller drops it once no sample follows.
  task automatic send_sample(logic [11:0] s, logic [3:0] ch, bit no_gap = 0);
    in_item_t it;
    int gap;
    it.sample = s;
    it.channel = ch;
    gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15));
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_amplitude(it);
    n_sent++;
  endtask

  task automatic send_window(logic [3:0] ch, int mode);
    for (int i = 0; i < WindowSamples; i++) begin
      case (mode)
        0: send_sample(12'($urandom_range(0, 4095)), ch);
        1: send_sample(12'hFFF, ch);
        2: send_sample(12'h000, ch);
        default: send_sample(((cos_tab(i) >= 0) ? 12'hFFF : 12'h000), ch);
      endcase
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (amp_queue.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CfgProcNoise: q_noise = val;
      CfgMeasNoise: r_noise = val;
      CfgInitVar: ;  // takes effect only at reset
      default: ;
    endcase
  endtask

  // Result checker with random receiver stall.
  initial begin
    int stall_left;
    out_item_t x;
    out_stall_i = 1'b1;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        if (amp_queue.size() == 0) begin
          $error("result with nothing expected: %p", out_data_o);
          errors++;
        end else begin
          x = amp_queue.pop_front();
          if (out_data_o.raw_amplitude !== x.raw_amplitude) begin
            $error("raw_amplitude exp %0d got %0d", x.raw_amplitude, out_data_o.raw_amplitude);
            errors++;
          end
          if (out_data_o.filtered_amplitude !== x.filtered_amplitude) begin
            $error("filtered_amplitude exp %0d got %0d",
                   x.filtered_amplitude, out_data_o.filtered_amplitude);
            errors++;
          end
          if (out_data_o.result_channel !== x.result_channel) begin
            $error("result_channel exp %0d got %0d",
                   x.result_channel, out_data_o.result_channel);
            errors++;
          end
          n_windows++;
        end
        stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall_i <= hold_off || (stall_left > 0);
    end
  end

  // Extreme samples, zero input, channel tag switching mid-window.
  task automatic test_directed();
    send_window(4'd0, 1);
    send_window(4'd1, 2);
    send_window(4'd2, 3);
    for (int i = 0; i < WindowSamples; i++)
      send_sample(12'($urandom_range(0, 4095)), 4'(i == WindowSamples - 1 ? 15 : i));
    drain();
  endtask

  // Registers at extremes, including the zero-divisor case.
  task automatic test_register_extremes();
    write_reg(CfgProcNoise, 16'hFFFF);
    write_reg(CfgMeasNoise, 16'h0000);
    write_reg(CfgInitVar, 16'hFFFF);
    send_window(4'd3, 1);
    send_window(4'd3, 0);
    drain();
    write_reg(CfgProcNoise, 16'h0000);
    write_reg(CfgMeasNoise, 16'hFFFF);
    write_reg(CfgInitVar, 16'h0000);
    send_window(4'd4, 1);
    drain();
    // With Q and R at zero, channel 6 variance collapses, then the divisor is zero.
    write_reg(CfgMeasNoise, 16'h0000);
    for (int i = 0; i < 4; i++) send_window(4'd6, 1);
    drain();
    write_reg(CfgNoReg, 16'h1234);  // unused index
    send_window(4'd5, 0);
    drain();
  endtask

  // Receiver holds off while the sender keeps offering samples.
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        for (int i = 0; i < 3 * WindowSamples; i++)
          send_sample(12'($urandom_range(0, 4095)), 4'($urandom_range(0, 15)), 1);
        in_valid_i <= 1'b0;
      end
      begin
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join
    drain();
  endtask

  // Random windows under several register settings; sender pauses between phases.
  task automatic test_random();
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CfgProcNoise, 16'($urandom_range(0, 65535)));
      write_reg(CfgMeasNoise, ph == 0 ? RstMeasNoise : 16'($urandom_range(0, 65535)));
      write_reg(CfgInitVar, 16'($urandom_range(0, 65535)));
      for (int w = 0; w < 20; w++)
        send_window(4'($urandom_range(0, 15)), ($urandom_range(0, 9) == 0) ? 1 : 0);
      drain();
    end
  endtask

  initial begin
    errors = 0;
    n_sent = 0;
    n_windows = 0;
    hold_off = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    q_noise = RstProcNoise;
    r_noise = RstMeasNoise;
    acc_cos = 0;
    acc_sin = 0;
    win_pos = 0;
    for (int i = 0; i < NumCh; i++) begin
      est_mem[i] = '0;
      var_mem[i] = RstInitVar;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_register_extremes();
    test_backpressure();
    test_random();
    drain();
    $display("Sent %0d samples, checked %0d windows over 16 channels,", n_sent, n_windows);
    $display("register extremes, zero divisor, mid-window channel change and back-pressure.");
    if (errors == 0) begin
      $display("[fundamental_amplitude_kalman_core] OK");
    end else begin
      $display("[fundamental_amplitude_kalman_core] ERROR");
    end
    $finish;
  end

endmodule
